>>> hw/rtl/psd_pkg.sv
// Shared widths, zone codes and pipeline side-band types for the point/segment distance unit
package psd_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 8;

   localparam int CW   = COORD_BITS;
   localparam int DW   = CW + 1;            // coordinate difference, signed
   localparam int PW   = 2 * DW;            // difference product, signed
   localparam int LW   = 2 * CW + 1;        // squared length, unsigned
   localparam int QW   = CW + FRAC_BITS;    // foot offset magnitude
   localparam int NW   = LW + QW;           // divider numerator
   localparam int NXW  = CW + FRAC_BITS + 1; // working width of nearest point
   localparam int OW   = CW + FRAC_BITS;    // nearest point output width
   localparam int EW   = CW + FRAC_BITS + 1; // error vector component, signed
   localparam int RW   = CW + FRAC_BITS + 1; // root width, also distance width
   localparam int D2W  = 2 * RW;            // squared distance

   localparam int FRONT_STAGES = 4;
   localparam int NEAR_STAGES  = 3;
   localparam int LATENCY      = FRONT_STAGES + QW + NEAR_STAGES + RW;

   typedef enum logic [1:0] {
      ZONE_FOOT   = 2'd0,
      ZONE_BEFORE = 2'd1,
      ZONE_PAST   = 2'd2,
      ZONE_ZERO   = 2'd3
   } zone_type;

   typedef struct packed {
      logic [CW-1:0] px;
      logic [CW-1:0] py;
      logic [CW-1:0] sx;
      logic [CW-1:0] sy;
      logic [CW-1:0] ex;
      logic [CW-1:0] ey;
      zone_type      zone;
      logic          neg_x;
      logic          neg_y;
   } side_type;

   typedef struct packed {
      logic [OW-1:0] near_x;
      logic [OW-1:0] near_y;
      zone_type      zone;
   } tag_type;

endpackage

>>> hw/rtl/psd_front.sv
// Front end: differences, products, length/dot sums, zone decision and divider numerators
module psd_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [psd_pkg::CW-1:0]     in_px,
   input  logic [psd_pkg::CW-1:0]     in_py,
   input  logic [psd_pkg::CW-1:0]     in_sx,
   input  logic [psd_pkg::CW-1:0]     in_sy,
   input  logic [psd_pkg::CW-1:0]     in_ex,
   input  logic [psd_pkg::CW-1:0]     in_ey,
   output logic                       out_valid,
   output psd_pkg::side_type          out_side,
   output logic [psd_pkg::NW-1:0]     out_num_x,
   output logic [psd_pkg::NW-1:0]     out_num_y,
   output logic [psd_pkg::LW-1:0]     out_den
);
   import psd_pkg::*;

   // stage 1
   logic             v1_ff;
   side_type         sd1_ff;
   logic signed [DW-1:0] dx1_ff, dy1_ff, ax1_ff, ay1_ff;
   // stage 2
   logic             v2_ff;
   side_type         sd2_ff;
   logic signed [DW-1:0] dx2_ff, dy2_ff;
   logic signed [PW-1:0] sqx2_ff, sqy2_ff, pdx2_ff, pdy2_ff;
   // stage 3
   logic             v3_ff;
   side_type         sd3_ff;
   logic signed [DW-1:0] dx3_ff, dy3_ff;
   logic [LW-1:0]        len3_ff;
   logic signed [PW-1:0] dot3_ff;
   // stage 4
   logic             v4_ff;
   side_type         sd4_ff;
   logic [NW-1:0]    nx4_ff, ny4_ff;
   logic [LW-1:0]    den4_ff;

   side_type             sd1_in;
   logic signed [DW-1:0] dx1_in, dy1_in, ax1_in, ay1_in;
   logic signed [PW:0]   len_sum, dot_sum;
   zone_type             zone_in;
   logic [CW-1:0]        mag_x, mag_y;
   logic [LW+CW-1:0]     prod_x, prod_y;
   side_type             sd4_in;
   logic [NW-1:0]        nx4_in, ny4_in;
   logic [LW-1:0]        den4_in;

   always_comb begin
      sd1_in       = '0;
      sd1_in.px    = in_px;
      sd1_in.py    = in_py;
      sd1_in.sx    = in_sx;
      sd1_in.sy    = in_sy;
      sd1_in.ex    = in_ex;
      sd1_in.ey    = in_ey;
      sd1_in.zone  = ZONE_FOOT;
      dx1_in = DW'($signed(in_ex)) - DW'($signed(in_sx));
      dy1_in = DW'($signed(in_ey)) - DW'($signed(in_sy));
      ax1_in = DW'($signed(in_px)) - DW'($signed(in_sx));
      ay1_in = DW'($signed(in_py)) - DW'($signed(in_sy));
   end

   assign len_sum = (PW+1)'(sqx2_ff) + (PW+1)'(sqy2_ff);
   assign dot_sum = (PW+1)'(pdx2_ff) + (PW+1)'(pdy2_ff);

   always_comb begin
      if (len3_ff == '0) begin
         zone_in = ZONE_ZERO;
      end else if (dot3_ff < 0) begin
         zone_in = ZONE_BEFORE;
      end else if (dot3_ff > $signed({1'b0, len3_ff})) begin
         zone_in = ZONE_PAST;
      end else begin
         zone_in = ZONE_FOOT;
      end
      mag_x  = dx3_ff[DW-1] ? CW'(-dx3_ff) : CW'(dx3_ff);
      mag_y  = dy3_ff[DW-1] ? CW'(-dy3_ff) : CW'(dy3_ff);
      prod_x = (LW+CW)'(dot3_ff[LW-1:0]) * (LW+CW)'(mag_x);
      prod_y = (LW+CW)'(dot3_ff[LW-1:0]) * (LW+CW)'(mag_y);
      sd4_in       = sd3_ff;
      sd4_in.zone  = zone_in;
      sd4_in.neg_x = dx3_ff[DW-1];
      sd4_in.neg_y = dy3_ff[DW-1];
      // only the foot case divides; the others run 0 / 1 through the divider
      if (zone_in == ZONE_FOOT) begin
         nx4_in  = NW'(prod_x) << FRAC_BITS;
         ny4_in  = NW'(prod_y) << FRAC_BITS;
         den4_in = len3_ff;
      end else begin
         nx4_in  = '0;
         ny4_in  = '0;
         den4_in = LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      sd1_ff  <= sd1_in;
      dx1_ff  <= dx1_in;
      dy1_ff  <= dy1_in;
      ax1_ff  <= ax1_in;
      ay1_ff  <= ay1_in;
      sd2_ff  <= sd1_ff;
      dx2_ff  <= dx1_ff;
      dy2_ff  <= dy1_ff;
      sqx2_ff <= PW'(dx1_ff) * PW'(dx1_ff);
      sqy2_ff <= PW'(dy1_ff) * PW'(dy1_ff);
      pdx2_ff <= PW'(ax1_ff) * PW'(dx1_ff);
      pdy2_ff <= PW'(ay1_ff) * PW'(dy1_ff);
      sd3_ff  <= sd2_ff;
      dx3_ff  <= dx2_ff;
      dy3_ff  <= dy2_ff;
      len3_ff <= len_sum[LW-1:0];
      dot3_ff <= dot_sum[PW-1:0];
      sd4_ff  <= sd4_in;
      nx4_ff  <= nx4_in;
      ny4_ff  <= ny4_in;
      den4_ff <= den4_in;
   end

   assign out_valid = v4_ff;
   assign out_side  = sd4_ff;
   assign out_num_x = nx4_ff;
   assign out_num_y = ny4_ff;
   assign out_den   = den4_ff;

endmodule

>>> hw/rtl/psd_div.sv
// Dual restoring divider pipeline, one quotient bit per stage for each axis
module psd_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  psd_pkg::side_type      in_side,
   input  logic [psd_pkg::NW-1:0] in_num_x,
   input  logic [psd_pkg::NW-1:0] in_num_y,
   input  logic [psd_pkg::LW-1:0] in_den,
   output logic                   out_valid,
   output psd_pkg::side_type      out_side,
   output logic [psd_pkg::QW-1:0] out_q_x,
   output logic [psd_pkg::QW-1:0] out_q_y,
   output logic                   out_rnz_x,
   output logic                   out_rnz_y
);
   import psd_pkg::*;

   logic          valid_st [0:QW];
   side_type      side_st  [0:QW];
   logic [LW-1:0] den_st   [0:QW];
   logic [LW-1:0] rx_st    [0:QW];
   logic [LW-1:0] ry_st    [0:QW];
   logic [QW-1:0] lx_st    [0:QW];
   logic [QW-1:0] ly_st    [0:QW];
   logic [QW-1:0] qx_st    [0:QW];
   logic [QW-1:0] qy_st    [0:QW];

   // quotient is known to fit QW bits, so the top part starts below the divisor
   assign valid_st[0] = in_valid;
   assign side_st[0]  = in_side;
   assign den_st[0]   = in_den;
   assign rx_st[0]    = in_num_x[NW-1:QW];
   assign ry_st[0]    = in_num_y[NW-1:QW];
   assign lx_st[0]    = in_num_x[QW-1:0];
   assign ly_st[0]    = in_num_y[QW-1:0];
   assign qx_st[0]    = '0;
   assign qy_st[0]    = '0;

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic          valid_ff;
      side_type      side_ff;
      logic [LW-1:0] den_ff, rx_ff, ry_ff, rx_in, ry_in;
      logic [QW-1:0] lx_ff, ly_ff, qx_ff, qy_ff;
      logic [LW:0]   tx, ty;
      logic          bx, by;

      always_comb begin
         tx    = {rx_st[k], lx_st[k][QW-1-k]};
         ty    = {ry_st[k], ly_st[k][QW-1-k]};
         bx    = tx >= {1'b0, den_st[k]};
         by    = ty >= {1'b0, den_st[k]};
         rx_in = bx ? LW'(tx - {1'b0, den_st[k]}) : tx[LW-1:0];
         ry_in = by ? LW'(ty - {1'b0, den_st[k]}) : ty[LW-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else begin
            valid_ff <= valid_st[k];
         end
      end

      always_ff @(posedge clock) begin
         side_ff <= side_st[k];
         den_ff  <= den_st[k];
         rx_ff   <= rx_in;
         ry_ff   <= ry_in;
         lx_ff   <= lx_st[k];
         ly_ff   <= ly_st[k];
         qx_ff   <= {qx_st[k][QW-2:0], bx};
         qy_ff   <= {qy_st[k][QW-2:0], by};
      end

      assign valid_st[k+1] = valid_ff;
      assign side_st[k+1]  = side_ff;
      assign den_st[k+1]   = den_ff;
      assign rx_st[k+1]    = rx_ff;
      assign ry_st[k+1]    = ry_ff;
      assign lx_st[k+1]    = lx_ff;
      assign ly_st[k+1]    = ly_ff;
      assign qx_st[k+1]    = qx_ff;
      assign qy_st[k+1]    = qy_ff;
   end

   assign out_valid = valid_st[QW];
   assign out_side  = side_st[QW];
   assign out_q_x   = qx_st[QW];
   assign out_q_y   = qy_st[QW];
   assign out_rnz_x = rx_st[QW] != '0;
   assign out_rnz_y = ry_st[QW] != '0;

endmodule

>>> hw/rtl/psd_near.sv
// Nearest point selection, error vector, its squares and the squared distance
module psd_near (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  psd_pkg::side_type       in_side,
   input  logic [psd_pkg::QW-1:0]  in_q_x,
   input  logic [psd_pkg::QW-1:0]  in_q_y,
   input  logic                    in_rnz_x,
   input  logic                    in_rnz_y,
   output logic                    out_valid,
   output psd_pkg::tag_type        out_tag,
   output logic [psd_pkg::D2W-1:0] out_d2
);
   import psd_pkg::*;

   logic                  va_ff, vb_ff, vc_ff;
   tag_type               ta_ff, tb_ff, tc_ff;
   logic signed [EW-1:0]  ex_ff, ey_ff;
   logic signed [2*EW-1:0] sx_ff, sy_ff;
   logic [D2W-1:0]        d2_ff;

   logic signed [QW:0]    qsx, qsy;
   logic signed [NXW-1:0] base_x, base_y, nx, ny, pxs, pys;
   logic signed [NXW:0]   ddx, ddy;
   logic [2*EW:0]         d2_sum;
   tag_type               ta_in;

   always_comb begin
      // floor of a negative quotient steps down once more on a remainder
      qsx = in_side.neg_x ? -$signed({1'b0, in_q_x}) - $signed((QW+1)'(in_rnz_x))
                          :  $signed({1'b0, in_q_x});
      qsy = in_side.neg_y ? -$signed({1'b0, in_q_y}) - $signed((QW+1)'(in_rnz_y))
                          :  $signed({1'b0, in_q_y});
      if (in_side.zone == ZONE_PAST) begin
         base_x = NXW'($signed(in_side.ex)) <<< FRAC_BITS;
         base_y = NXW'($signed(in_side.ey)) <<< FRAC_BITS;
      end else begin
         base_x = NXW'($signed(in_side.sx)) <<< FRAC_BITS;
         base_y = NXW'($signed(in_side.sy)) <<< FRAC_BITS;
      end
      nx  = base_x + NXW'(qsx);
      ny  = base_y + NXW'(qsy);
      pxs = NXW'($signed(in_side.px)) <<< FRAC_BITS;
      pys = NXW'($signed(in_side.py)) <<< FRAC_BITS;
      ddx = (NXW+1)'(pxs) - (NXW+1)'(nx);
      ddy = (NXW+1)'(pys) - (NXW+1)'(ny);
      ta_in.near_x = nx[OW-1:0];
      ta_in.near_y = ny[OW-1:0];
      ta_in.zone   = in_side.zone;
   end

   assign d2_sum = (2*EW+1)'(sx_ff) + (2*EW+1)'(sy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      ta_ff <= ta_in;
      ex_ff <= ddx[EW-1:0];
      ey_ff <= ddy[EW-1:0];
      tb_ff <= ta_ff;
      sx_ff <= (2*EW)'(ex_ff) * (2*EW)'(ex_ff);
      sy_ff <= (2*EW)'(ey_ff) * (2*EW)'(ey_ff);
      tc_ff <= tb_ff;
      d2_ff <= d2_sum[D2W-1:0];
   end

   assign out_valid = vc_ff;
   assign out_tag   = tc_ff;
   assign out_d2    = d2_ff;

endmodule

>>> hw/rtl/psd_sqrt.sv
// Integer square root pipeline, one root bit per stage
module psd_sqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  psd_pkg::tag_type        in_tag,
   input  logic [psd_pkg::D2W-1:0] in_d2,
   output logic                    out_valid,
   output psd_pkg::tag_type        out_tag,
   output logic [psd_pkg::RW-1:0]  out_root
);
   import psd_pkg::*;

   logic           valid_st [0:RW];
   tag_type        tag_st   [0:RW];
   logic [D2W-1:0] x_st     [0:RW];
   logic [RW+1:0]  rem_st   [0:RW];
   logic [RW-1:0]  root_st  [0:RW];

   assign valid_st[0] = in_valid;
   assign tag_st[0]   = in_tag;
   assign x_st[0]     = in_d2;
   assign rem_st[0]   = '0;
   assign root_st[0]  = '0;

   for (genvar k = 0; k < RW; k++) begin : g_step
      logic           valid_ff;
      tag_type        tag_ff;
      logic [D2W-1:0] x_ff;
      logic [RW+1:0]  rem_ff, rem_in;
      logic [RW-1:0]  root_ff;
      logic [RW+3:0]  t, trial;
      logic           take;

      always_comb begin
         t      = {rem_st[k], x_st[k][D2W-1-2*k -: 2]};
         trial  = {2'b00, root_st[k], 2'b01};
         take   = t >= trial;
         rem_in = take ? (RW+2)'(t - trial) : t[RW+1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else begin
            valid_ff <= valid_st[k];
         end
      end

      always_ff @(posedge clock) begin
         tag_ff  <= tag_st[k];
         x_ff    <= x_st[k];
         rem_ff  <= rem_in;
         root_ff <= {root_st[k][RW-2:0], take};
      end

      assign valid_st[k+1] = valid_ff;
      assign tag_st[k+1]   = tag_ff;
      assign x_st[k+1]     = x_ff;
      assign rem_st[k+1]   = rem_ff;
      assign root_st[k+1]  = root_ff;
   end

   assign out_valid = valid_st[RW];
   assign out_tag   = tag_st[RW];
   assign out_root  = root_st[RW];

endmodule

>>> hw/rtl/point_segment_distance_unit.sv
// Pipeline from the start transfer to rsp_strobe: 4 front, 24 divide, 3 near and 25 root stages.
// Throughput: one query per cycle; every stage is a plain register, busy is never raised.
// The divider and square-root pipelines each resolve one bit per stage.
// Reset clears all valid bits so no strobe appears until a started query drains out.
// Results are not held: the receiver must take each one in its strobe cycle.
module point_segment_distance_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [psd_pkg::CW-1:0] req_point_x,
   input  logic [psd_pkg::CW-1:0] req_point_y,
   input  logic [psd_pkg::CW-1:0] req_seg_start_x,
   input  logic [psd_pkg::CW-1:0] req_seg_start_y,
   input  logic [psd_pkg::CW-1:0] req_seg_end_x,
   input  logic [psd_pkg::CW-1:0] req_seg_end_y,
   output logic                   rsp_strobe,
   output logic [psd_pkg::RW-1:0] rsp_distance,
   output logic [psd_pkg::OW-1:0] rsp_near_x,
   output logic [psd_pkg::OW-1:0] rsp_near_y,
   output logic [1:0]             rsp_zone
);
   import psd_pkg::*;

   logic          f_valid, d_valid, n_valid, s_valid;
   side_type      f_side, d_side;
   logic [NW-1:0] f_num_x, f_num_y;
   logic [LW-1:0] f_den;
   logic [QW-1:0] d_q_x, d_q_y;
   logic          d_rnz_x, d_rnz_y;
   tag_type       n_tag, s_tag;
   logic [D2W-1:0] n_d2;
   logic [RW-1:0] s_root;

   assign busy = 1'b0;

   psd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_px     (req_point_x),
      .in_py     (req_point_y),
      .in_sx     (req_seg_start_x),
      .in_sy     (req_seg_start_y),
      .in_ex     (req_seg_end_x),
      .in_ey     (req_seg_end_y),
      .out_valid (f_valid),
      .out_side  (f_side),
      .out_num_x (f_num_x),
      .out_num_y (f_num_y),
      .out_den   (f_den)
   );

   psd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_side   (f_side),
      .in_num_x  (f_num_x),
      .in_num_y  (f_num_y),
      .in_den    (f_den),
      .out_valid (d_valid),
      .out_side  (d_side),
      .out_q_x   (d_q_x),
      .out_q_y   (d_q_y),
      .out_rnz_x (d_rnz_x),
      .out_rnz_y (d_rnz_y)
   );

   psd_near u_near (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .in_side   (d_side),
      .in_q_x    (d_q_x),
      .in_q_y    (d_q_y),
      .in_rnz_x  (d_rnz_x),
      .in_rnz_y  (d_rnz_y),
      .out_valid (n_valid),
      .out_tag   (n_tag),
      .out_d2    (n_d2)
   );

   psd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (n_valid),
      .in_tag    (n_tag),
      .in_d2     (n_d2),
      .out_valid (s_valid),
      .out_tag   (s_tag),
      .out_root  (s_root)
   );

   assign rsp_strobe   = s_valid;
   assign rsp_distance = s_root;
   assign rsp_near_x   = s_tag.near_x;
   assign rsp_near_y   = s_tag.near_y;
   assign rsp_zone     = s_tag.zone;

   a_start_gives_result: assert property (@(posedge clock) disable iff (reset)
      start |-> ##LATENCY rsp_strobe)
      else $error("started query did not produce a result");

   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      !start |-> ##LATENCY !rsp_strobe)
      else $error("result strobe without a started query");

   a_zero_length_zone: assert property (@(posedge clock) disable iff (reset)
      (start && req_seg_start_x == req_seg_end_x && req_seg_start_y == req_seg_end_y)
      |-> ##LATENCY (rsp_zone == ZONE_ZERO))
      else $error("zero-length segment not flagged");

endmodule
